// ----- hdl/texp_pkg.sv -----
// ----------------------------------------------------------------------------
// texp_pkg: shared types and constants for the taylor exponential block
// Fixed-point formats, series length and the data word that runs down the
// chain of Horner cells.
// ----------------------------------------------------------------------------
package texp_pkg;

  // number of series terms, n = 0 .. TERMS-1 (range 2 .. 256)
  localparam int unsigned TERMS  = 40;
  localparam int unsigned STAGES = TERMS - 1;

  localparam int unsigned X_W    = 16;  // signed Q4.12 exponent
  localparam int unsigned MX_W   = 16;  // |x|, up to 2^15
  localparam int unsigned MAG_W  = 44;  // |acc| in Q.32, clamped
  localparam int unsigned T_W    = 47;  // rounded |acc|*|x| in Q.32
  localparam int unsigned RCP_W  = 33;  // reciprocal 1/n in Q0.32, 1/1 = 2^32
  localparam int unsigned HI_W   = 64;  // upper partial product
  localparam int unsigned LO_W   = 49;  // lower partial product
  localparam int unsigned Q_W    = 49;  // scaled term
  localparam int unsigned OUT_W  = 32;  // unsigned Q12.20

  localparam logic [MAG_W-1:0] ONE_Q32   = MAG_W'(64'd1 << 32);
  localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

  // word handed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic             xneg;
    logic [MX_W-1:0]  mx;
    logic             aneg;
    logic [MAG_W-1:0] amag;
  } stage_t;

endpackage

// ----- hdl/texp_cell.sv -----
// ----------------------------------------------------------------------------
// texp_cell: one Horner step of the exponential series
// Computes acc' = 1 +/- round(round(|acc|*|x|) * (1/n)) over three register
// stages: magnitude product, reciprocal partial products, sum and clamp.
// ----------------------------------------------------------------------------
module texp_cell import texp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [RCP_W-1:0] recip_i,
  input  stage_t           in_i,
  output stage_t           out_o
);

  // stage a: |acc| * |x|, rounded back to Q.32
  logic            a_valid_q;
  logic            a_xneg_q, a_aneg_q;
  logic [MX_W-1:0] a_mx_q;
  logic [T_W-1:0]  a_t_q, a_t_d;
  logic [59:0]     prod;

  // stage b: t * recip split into two partial products
  logic            b_valid_q;
  logic            b_xneg_q, b_aneg_q;
  logic [MX_W-1:0] b_mx_q;
  logic [HI_W-1:0] b_hi_q, b_hi_d;
  logic [LO_W-1:0] b_lo_q, b_lo_d;

  // stage c: accumulate term and clamp
  logic [64:0]      sum;
  logic [Q_W-1:0]   term;
  logic             neg;
  logic [Q_W:0]     pos_val;
  logic [Q_W-1:0]   neg_diff;
  logic             c_aneg_d;
  logic [MAG_W-1:0] c_amag_d;
  logic             c_valid_q;
  logic             c_xneg_q, c_aneg_q;
  logic [MX_W-1:0]  c_mx_q;
  logic [MAG_W-1:0] c_amag_q;

  assign prod  = 60'(in_i.amag) * 60'(in_i.mx);
  assign a_t_d = T_W'((prod + 60'd2048) >> 12);

  assign b_hi_d = HI_W'(a_t_q[T_W-1:16]) * HI_W'(recip_i);
  assign b_lo_d = LO_W'(a_t_q[15:0]) * LO_W'(recip_i);

  always_comb begin
    sum      = 65'(b_hi_q) + 65'(b_lo_q >> 16);
    term     = Q_W'((sum + 65'd32768) >> 16);
    neg      = b_aneg_q ^ b_xneg_q;
    pos_val  = (Q_W+1)'(ONE_Q32) + (Q_W+1)'(term);
    neg_diff = term - Q_W'(ONE_Q32);
    c_aneg_d = 1'b0;
    c_amag_d = MAG_LIMIT;
    if (!neg) begin
      if (pos_val <= (Q_W+1)'(MAG_LIMIT)) begin
        c_amag_d = MAG_W'(pos_val);
      end
    end else if (term <= Q_W'(ONE_Q32)) begin
      c_amag_d = ONE_Q32 - MAG_W'(term);
    end else begin
      c_aneg_d = 1'b1;
      if (neg_diff <= Q_W'(MAG_LIMIT)) begin
        c_amag_d = MAG_W'(neg_diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_xneg_q <= in_i.xneg;
      a_aneg_q <= in_i.aneg;
      a_mx_q   <= in_i.mx;
      a_t_q    <= a_t_d;
      b_xneg_q <= a_xneg_q;
      b_aneg_q <= a_aneg_q;
      b_mx_q   <= a_mx_q;
      b_hi_q   <= b_hi_d;
      b_lo_q   <= b_lo_d;
      c_xneg_q <= b_xneg_q;
      c_mx_q   <= b_mx_q;
      c_aneg_q <= c_aneg_d;
      c_amag_q <= c_amag_d;
    end
  end

  assign out_o.valid = c_valid_q;
  assign out_o.xneg  = c_xneg_q;
  assign out_o.mx    = c_mx_q;
  assign out_o.aneg  = c_aneg_q;
  assign out_o.amag  = c_amag_q;

endmodule

// ----- hdl/taylor_exponential.sv -----
// ----------------------------------------------------------------------------
// taylor_exponential: e^x from the Taylor series in Horner form
// Each result passes the three registers of every Horner cell, then the output
// register. Throughput: one item per cycle while the skid entry is free.
// A two-entry output buffer lets the chain run while a result waits.
// Reset clears all valid bits; no other state is kept between items.
// ----------------------------------------------------------------------------
module taylor_exponential import texp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [X_W-1:0]   exponent_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_W-1:0]        exp_value_o
);

  stage_t chain [STAGES+1];

  logic              en;
  logic              xneg;
  logic [OUT_W-1:0]  res;
  logic [OUT_W:0]    rnd;
  logic              tail_vld;

  logic              out_vld_q, skid_vld_q;
  logic [OUT_W-1:0]  out_q, skid_q;

  // chain advances while the skid entry is free
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  assign xneg            = exponent_i[X_W-1];
  assign chain[0].valid  = in_valid_i;
  assign chain[0].xneg   = xneg;
  assign chain[0].mx     = xneg ? MX_W'(-exponent_i) : MX_W'(exponent_i);
  assign chain[0].aneg   = 1'b0;
  assign chain[0].amag   = ONE_Q32;

  // cell g evaluates the step for n = TERMS-1-g
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    localparam int unsigned N = TERMS - 1 - g;
    localparam logic [63:0] Recip = ((64'd1 << 32) + 64'(N / 2)) / 64'(N);

    texp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .recip_i (Recip[RCP_W-1:0]),
      .in_i    (chain[g]),
      .out_o   (chain[g+1])
    );
  end

  // final rounding to Q12.20 with saturation
  always_comb begin
    rnd = (OUT_W+1)'(((MAG_W+1)'(chain[STAGES].amag) + (MAG_W+1)'(2048)) >> 12);
    if (chain[STAGES].aneg || chain[STAGES].amag == '0) begin
      res = '0;
    end else if (rnd[OUT_W]) begin
      res = '1;
    end else begin
      res = rnd[OUT_W-1:0];
    end
  end

  assign tail_vld = en && chain[STAGES].valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_q  <= skid_vld_q || tail_vld;
        skid_vld_q <= 1'b0;
      end else if (tail_vld) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end
    if (tail_vld && out_vld_q && !out_ready_i) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign exp_value_o = out_q;

endmodule

// ----- hdl/texp_checker.sv -----
// ----------------------------------------------------------------------------
// texp_checker: port-level checks for taylor_exponential
// Watches the handshakes and the output buffer behavior seen at the ports.
// ----------------------------------------------------------------------------
module texp_checker import texp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] exp_value_o
);

  // input stalls only when the output holds a result
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a taken result frees the buffer for the next cycle
  a_stall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !in_ready_o) |=> in_ready_o)
    else $error("input still stalled after result taken");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output item dropped before accept");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(exp_value_o))
    else $error("output item changed before accept");

endmodule

bind taylor_exponential texp_checker u_texp_checker (.*);
